### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lkvc checker: property failed");

// Check a property on every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lkvc checker: property failed");

`endif

### rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Widths, sizes and codes of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES = 16;                      // slots in the store (1 .. 64)
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int CAP_W   = 5;                       // capacity register width
   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W   = $clog2(ENTRIES + 1);
   localparam int CMP_W   = (CAP_W > OCC_W) ? CAP_W : OCC_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      ACT_LOOKUP = 1'b0,
      ACT_STORE  = 1'b1
   } action_type;

   typedef logic [RANK_W-1:0] rank_type;

endpackage

### rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache with least-recently-used replacement.
//
// Each request beat is a lookup or a store and yields exactly one response
// beat. A beat is captured into an input register, then resolved in one pass
// of logic (a parallel compare of the key against all slots, selection of the
// slot to touch and an update of every slot's age rank) whose outcome is
// written into the slot state and the response register at the same edge.
// One beat is taken per cycle when the response side keeps up; a request
// beat passes the input register, then the response register, and its
// response beat can leave at the following edge. Lookups that
// hit return the value and make the slot most recent; misses return all ones
// with found clear. Stores update a held key, fill a free slot while
// occupancy is below capacity, or else overwrite the least recent slot; with
// capacity zero they change nothing. Capacity above the slot count
// saturates; write it only while idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [lkvc_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lkvc_pkg::VAL_W-1:0]   req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic signed [lkvc_pkg::VAL_W-1:0]   rsp_read_value,
   // capacity register
   input  logic                                csr_wr_en,
   input  logic        [lkvc_pkg::CAP_W-1:0]   csr_wr_data
);
   import lkvc_pkg::*;

   // Capacity register.
   logic [CAP_W-1:0]     capacity_ff;

   // Input register.
   logic                 s_vld_ff, s_vld_in;
   logic                 s_action_ff;
   logic [KEY_W-1:0]     s_key_ff;
   logic [VAL_W-1:0]     s_value_ff;

   // Slot state.
   logic [KEY_W-1:0]     key_ff   [ENTRIES];
   logic [VAL_W-1:0]     val_ff   [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   rank_type             rank_ff  [ENTRIES];
   rank_type             rank_in  [ENTRIES];
   logic [OCC_W-1:0]     occ_ff, occ_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic [VAL_W-1:0]     rsp_value_ff;

   // Single-pass resolve logic.
   logic                 advance;
   logic                 req_accept;
   logic [CMP_W-1:0]     cap_eff;
   logic [CMP_W-1:0]     occ_cmp;
   logic                 is_store;
   logic                 store_en;
   logic                 hit;
   logic                 has_room;
   logic                 do_fill;
   logic [ENTRIES-1:0]   hit_vec;
   logic [ENTRIES-1:0]   fill_vec;
   logic [ENTRIES-1:0]   old_vec;
   logic [ENTRIES-1:0]   touch_vec;
   logic [RANK_W:0]      touch_rank;
   logic [VAL_W-1:0]     hit_value;

   // Resolve a beat when the response register is free or being emptied.
   assign advance    = s_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s_vld_ff || !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Saturate the usable capacity at the slot count.
   always_comb begin
      cap_eff = (CMP_W'(capacity_ff) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                        : CMP_W'(capacity_ff);
      occ_cmp = CMP_W'(occ_ff);
   end

   assign is_store = (action_type'(s_action_ff) == ACT_STORE);
   assign store_en = is_store && (cap_eff != '0);
   assign has_room = occ_cmp < cap_eff;

   // Compare against every slot; valid keys are distinct, so at most one hits.
   // Slots fill in order and never empty, so the free slot is the one
   // numbered by the occupancy, and the least recent holds rank occupancy-1.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]  = valid_ff[i] && (key_ff[i] == s_key_ff);
         fill_vec[i] = (occ_ff == OCC_W'(i));
         old_vec[i]  = valid_ff[i] && (OCC_W'(rank_ff[i]) == (occ_ff - OCC_W'(1)));
      end
   end

   assign hit     = |hit_vec;
   assign do_fill = store_en && !hit && has_room;

   // Pick the slot this beat makes most recent.
   always_comb begin
      if (!is_store) begin
         touch_vec = hit_vec;
      end else if (!store_en) begin
         touch_vec = '0;
      end else if (hit) begin
         touch_vec = hit_vec;
      end else if (has_room) begin
         touch_vec = fill_vec;
      end else begin
         touch_vec = old_vec;
      end
   end

   // Rank of the touched slot; a fill ages every valid slot.
   always_comb begin
      touch_rank = '0;
      hit_value  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         touch_rank = touch_rank | ({(RANK_W+1){touch_vec[i]}} & (RANK_W+1)'(rank_ff[i]));
         hit_value  = hit_value  | ({VAL_W{hit_vec[i]}} & val_ff[i]);
      end
      if (do_fill) begin
         touch_rank = (RANK_W+1)'(ENTRIES);
      end
   end

   // Next slot control state.
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (advance) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (touch_vec[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && ((RANK_W+1)'(rank_ff[i]) < touch_rank)) begin
               rank_in[i] = rank_ff[i] + rank_type'(1);
            end
         end
         if (do_fill) begin
            valid_in = valid_ff | fill_vec;
            occ_in   = occ_ff + OCC_W'(1);
         end
      end
   end

   // Hold the input register until the beat is resolved.
   always_comb begin
      if (req_accept) begin
         s_vld_in = 1'b1;
      end else if (advance) begin
         s_vld_in = 1'b0;
      end else begin
         s_vld_in = s_vld_ff;
      end
   end

   // Drop the response once taken unless a new one replaces it.
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         s_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         s_vld_ff     <= s_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Payload registers: input beat, slot contents, response.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s_action_ff <= req_action;
         s_key_ff    <= req_key;
         s_value_ff  <= req_value;
      end
      if (advance) begin
         rsp_found_ff <= hit;
         rsp_value_ff <= (!is_store && hit) ? hit_value : '1;
         if (store_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (touch_vec[i]) begin
                  key_ff[i] <= s_key_ff;
                  val_ff[i] <= s_value_ff;
               end
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

### rtl/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkvc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_found,
   input logic signed [lkvc_pkg::VAL_W-1:0]   rsp_read_value
);
   import lkvc_pkg::*;

   // No response beat right after reset, and the request side opens at once.
   `CHK_ASSERT_ALWAYS(a_rst_no_rsp, clock, reset |=> !rsp_valid)
   `CHK_ASSERT_ALWAYS(a_rst_ready, clock, reset |=> req_ready)

   // A response without found always reads all ones.
   `CHK_ASSERT(a_miss_all_ones, clock, reset,
      (rsp_valid && !rsp_found) |-> (rsp_read_value == '1))

   // A stalled response beat holds.
   `CHK_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_read_value)))

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);

### dv/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_tb
// Self-checking bench for the LRU key/value cache. A scoreboard object keeps
// its own copy of the slots, age ranks and capacity, predicts found and
// read_value for every request beat taken, and checks the response beats in
// order. The stimulus is a directed opening followed by random phases, each
// under its own capacity setting, with bursty requests and a stalling
// response side.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit_tb;

   import lkvc_pkg::*;

   localparam logic [KEY_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [KEY_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam int               POOL_SIZE = 32;
   localparam int               PHASES = 9;

   // Response side behaviour, picked anew for each random stretch.
   typedef enum int {
      RDY_ALWAYS,
      RDY_MOSTLY,
      RDY_RARELY,
      RDY_BURSTY
   } ready_mode_type;

   typedef struct {
      bit             found;
      bit [VAL_W-1:0] read_value;
   } cache_reply_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the cache contents plus the queue of replies owed.
   // -------------------------------------------------------------------------
   class cache_scoreboard;
      bit [KEY_W-1:0]  slot_key[ENTRIES];
      bit [VAL_W-1:0]  slot_value[ENTRIES];
      bit              slot_used[ENTRIES];
      int unsigned     slot_age[ENTRIES];
      int unsigned     occupancy;
      bit [CAP_W-1:0]  capacity = CAP_RESET;
      cache_reply_type replies_owed[$];
      int              errors;

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
         errors++;
      endtask

      // Age every used slot younger than s by one and make s the youngest.
      function void promote(int s);
         for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && i != s && slot_age[i] < slot_age[s])
               slot_age[i]++;
         slot_age[s] = 0;
      endfunction

      function void note_request(action_type act, bit [KEY_W-1:0] key,
                                 bit [VAL_W-1:0] value);
         int              hit_slot;
         int              slot;
         int unsigned     usable;
         cache_reply_type reply;
         hit_slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (hit_slot < 0 && slot_used[i] && slot_key[i] == key)
               hit_slot = i;
         usable = (capacity > ENTRIES) ? ENTRIES : capacity;
         reply.found      = (hit_slot >= 0);
         reply.read_value = '1;
         if (act == ACT_LOOKUP) begin
            if (hit_slot >= 0) begin
               reply.read_value = slot_value[hit_slot];
               promote(hit_slot);
            end
         end else if (usable != 0) begin
            if (hit_slot >= 0) begin
               promote(hit_slot);
               slot_value[hit_slot] = value;
            end else begin
               slot = -1;
               if (occupancy < usable)
                  for (int i = 0; i < ENTRIES; i++)
                     if (slot < 0 && !slot_used[i])
                        slot = i;
               if (slot >= 0) begin
                  // fill a free slot: everything already held gets older
                  for (int i = 0; i < ENTRIES; i++)
                     if (slot_used[i])
                        slot_age[i]++;
                  slot_used[slot] = 1'b1;
                  slot_age[slot]  = 0;
                  occupancy++;
               end else begin
                  // evict the oldest slot
                  for (int i = 0; i < ENTRIES; i++)
                     if (slot_used[i] && (slot < 0 || slot_age[i] > slot_age[slot]))
                        slot = i;
                  if (slot >= 0)
                     promote(slot);
               end
               if (slot >= 0) begin
                  slot_key[slot]   = key;
                  slot_value[slot] = value;
               end
            end
         end
         replies_owed.push_back(reply);
      endfunction

      task check_response(logic found, logic [VAL_W-1:0] read_value);
         cache_reply_type want;
         if (replies_owed.size() == 0) begin
            report("response beat with nothing owed", {31'b0, found}, '0);
         end else begin
            want = replies_owed.pop_front();
            if (found !== want.found)
               report("found", {31'b0, found}, {31'b0, want.found});
            if (read_value !== want.read_value)
               report("read_value", read_value, want.read_value);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block signals
   // -------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_action = 1'b0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_found;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                    csr_wr_en = 1'b0;
   logic        [CAP_W-1:0] csr_wr_data = '0;

   cache_scoreboard         sb = new;
   logic [KEY_W-1:0]        key_pool[POOL_SIZE];
   ready_mode_type          ready_mode = RDY_ALWAYS;
   int                      mode_left;
   int                      stall_left;

   always #5 clock = ~clock;

   lru_key_value_cache_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. Note the request beat
   // before checking the response; a reply can never leave on the same edge
   // its request arrives.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(action_type'(req_action), req_key, req_value);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_found, rsp_read_value);
      end
   end

   // -------------------------------------------------------------------------
   // Response side: pick a stall pattern for a random stretch, then hold it.
   // The bursty pattern now and then throws in a stall.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            RDY_ALWAYS: rsp_ready <= 1'b1;
            RDY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 7) == 0)
                  stall_left = $urandom_range(1, 12);
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks. Everything changes at the falling edge; valid is only ever
   // lowered by idle_for or drain, never between two back-to-back beats.
   // -------------------------------------------------------------------------
   task send_request(action_type act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= key;
      req_value  <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task idle_for(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1)
         @(negedge clock);
   endtask

   // Drop valid and hold off until every reply owed has come back, then wait
   // on to cover the two-stage pipe.
   task drain();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.replies_owed.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4)
         @(posedge clock);
   endtask

   // The capacity register may only change while the block is idle.
   task set_capacity(logic [CAP_W-1:0] cap);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.capacity = cap;
   endtask

   // Random beats drawn mostly from a small key pool so that hits, updates
   // and evictions all happen; a few fully random keys keep every key bit
   // moving. Bursts of 1..16 beats, with gaps unless the phase runs flat out.
   task run_random(int count, int pool_used, bit with_gaps);
      int               burst;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      burst = $urandom_range(1, 16);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 8)
            key = $urandom;
         else
            key = key_pool[$urandom_range(0, pool_used - 1)];
         case ($urandom_range(0, 19))
            0:       value = WORD_MIN;
            1:       value = WORD_MAX;
            2:       value = '0;
            3:       value = '1;
            default: value = $urandom;
         endcase
         send_request(action_type'($urandom_range(0, 1)), key, value);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            if (with_gaps)
               idle_for($urandom_range(1, 6));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int          phase_cap[PHASES];
      int          pool_used;
      int unsigned usable;
      // extremes first, then a sweep that ends back at full size
      phase_cap = '{16, 4, 31, 1, 0, 12, 17, 2, 16};
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = WORD_MIN;
      key_pool[3] = WORD_MAX;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      repeat (10)
         @(negedge clock);
      reset <= 1'b0;

      // Directed: lookups into an empty cache, stores at the key and value
      // extremes, hits, and an update of a key already held.
      set_capacity(5'd16);
      send_request(ACT_LOOKUP, '0, '0);
      send_request(ACT_LOOKUP, WORD_MIN, WORD_MAX);
      send_request(ACT_STORE,  WORD_MIN, WORD_MAX);
      send_request(ACT_STORE,  WORD_MAX, WORD_MIN);
      send_request(ACT_STORE,  '0, '0);
      send_request(ACT_STORE,  '1, '1);
      send_request(ACT_LOOKUP, WORD_MIN, '0);
      send_request(ACT_LOOKUP, '1, '0);
      send_request(ACT_LOOKUP, '0, '1);
      send_request(ACT_STORE,  WORD_MIN, 32'h5A5A_A5A5);
      send_request(ACT_LOOKUP, WORD_MIN, '0);
      send_request(ACT_LOOKUP, 32'h0000_3039, '0);

      // Shrink below the occupancy: nothing is dropped, new keys evict.
      set_capacity(5'd1);
      send_request(ACT_STORE,  32'h0000_1234, 32'hCAFE_0001);
      send_request(ACT_LOOKUP, 32'h0000_1234, '0);
      send_request(ACT_STORE,  32'h0000_0055, 32'hCAFE_0002);
      send_request(ACT_LOOKUP, 32'h0000_1234, '0);

      // Capacity zero: stores leave everything alone but still report found.
      set_capacity(5'd0);
      send_request(ACT_STORE,  32'h0000_0055, 32'h0000_0007);
      send_request(ACT_STORE,  32'h0000_0063, 32'h0000_0008);
      send_request(ACT_LOOKUP, 32'h0000_0055, '0);
      send_request(ACT_LOOKUP, 32'h0000_0063, '0);

      // Random phases. Every third phase runs without sender gaps; every
      // phase boundary waits for all replies before the register write.
      for (int p = 0; p < PHASES; p++) begin
         set_capacity(CAP_W'(phase_cap[p]));
         usable    = (phase_cap[p] > ENTRIES) ? ENTRIES : phase_cap[p];
         pool_used = (usable + 6 > POOL_SIZE) ? POOL_SIZE : usable + 6;
         run_random(200, pool_used, (p % 3) != 1);
      end

      drain();
      repeat (8)
         @(posedge clock);
      if (sb.replies_owed.size() != 0)
         sb.report("replies never returned", sb.replies_owed.size(), 0);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: a correct run finishes well before this limit even with the
   // longest gaps and stalls on every beat.
   initial begin
      #(5_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### lru_key_value_cache_unit.f
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache_unit.sv
rtl/lkvc_checker.sv
dv/lru_key_value_cache_unit_tb.sv
